// ===== hdl/jtsq_pkg.sv =====
// Shared types, tap state codes, path table and microcode for the JTAG TAP master sequencer.
`default_nettype none
package jtsq_pkg;

    // Tap state codes
    localparam logic [3:0] ST_TLR   = 4'd0;
    localparam logic [3:0] ST_SHDR  = 4'd4;
    localparam logic [3:0] ST_EX1DR = 4'd5;
    localparam logic [3:0] ST_SHIR  = 4'd11;
    localparam logic [3:0] ST_EX1IR = 4'd12;

    // Item kinds
    localparam logic [1:0] KIND_GOTO  = 2'd0;
    localparam logic [1:0] KIND_SHIFT = 2'd1;
    localparam logic [1:0] KIND_RAW   = 2'd2;

    localparam int RESET_CLOCKS = 9;
    localparam int MAX_RESULTS  = 10;
    // reset walk length, capped so one item never exceeds MAX_RESULTS words
    localparam int RST_GOTO_CLOCKS =
        (RESET_CLOCKS > MAX_RESULTS) ? MAX_RESULTS : RESET_CLOCKS;
    localparam int RST_SHIFT_CLOCKS =
        (RESET_CLOCKS > MAX_RESULTS - 1) ? MAX_RESULTS - 1 : RESET_CLOCKS;

    // Shortest TMS path [from][to]: bits [11:4] TMS sequence LSB first, [3:0] length
    localparam logic [11:0] PATH_TAB [16][16] = '{
        '{12'h011, 12'h001, 12'h022, 12'h023, 12'h024, 12'h0a4, 12'h0a5, 12'h2a6,
          12'h1a5, 12'h063, 12'h064, 12'h065, 12'h165, 12'h166, 12'h567, 12'h366},
        '{12'h073, 12'h001, 12'h011, 12'h012, 12'h013, 12'h053, 12'h054, 12'h155,
          12'h0d4, 12'h032, 12'h033, 12'h034, 12'h0b4, 12'h0b5, 12'h2b6, 12'h1b5},
        '{12'h032, 12'h033, 12'h000, 12'h001, 12'h002, 12'h022, 12'h023, 12'h0a4,
          12'h063, 12'h011, 12'h012, 12'h013, 12'h053, 12'h054, 12'h155, 12'h0d4},
        '{12'h1f5, 12'h033, 12'h073, 12'h000, 12'h001, 12'h011, 12'h012, 12'h053,
          12'h032, 12'h0f4, 12'h0f5, 12'h0f6, 12'h2f6, 12'h2f7, 12'haf8, 12'h6f7},
        '{12'h1f5, 12'h033, 12'h073, 12'h074, 12'h001, 12'h011, 12'h012, 12'h053,
          12'h032, 12'h0f4, 12'h0f5, 12'h0f6, 12'h2f6, 12'h2f7, 12'haf8, 12'h6f7},
        '{12'h0f4, 12'h012, 12'h032, 12'h033, 12'h023, 12'h000, 12'h001, 12'h022,
          12'h011, 12'h073, 12'h074, 12'h075, 12'h175, 12'h176, 12'h577, 12'h376},
        '{12'h1f5, 12'h033, 12'h073, 12'h074, 12'h012, 12'h053, 12'h001, 12'h011,
          12'h032, 12'h0f4, 12'h0f5, 12'h0f6, 12'h2f6, 12'h2f7, 12'haf8, 12'h6f7},
        '{12'h0f4, 12'h012, 12'h032, 12'h033, 12'h001, 12'h022, 12'h023, 12'h000,
          12'h011, 12'h073, 12'h074, 12'h075, 12'h175, 12'h176, 12'h577, 12'h376},
        '{12'h073, 12'h001, 12'h011, 12'h012, 12'h013, 12'h053, 12'h054, 12'h155,
          12'h000, 12'h032, 12'h033, 12'h034, 12'h0b4, 12'h0b5, 12'h2b6, 12'h1b5},
        '{12'h011, 12'h012, 12'h053, 12'h054, 12'h055, 12'h155, 12'h156, 12'h557,
          12'h356, 12'h000, 12'h001, 12'h002, 12'h022, 12'h023, 12'h0a4, 12'h063},
        '{12'h1f5, 12'h033, 12'h073, 12'h074, 12'h075, 12'h175, 12'h176, 12'h577,
          12'h376, 12'h0f4, 12'h000, 12'h001, 12'h011, 12'h012, 12'h053, 12'h032},
        '{12'h1f5, 12'h033, 12'h073, 12'h074, 12'h075, 12'h175, 12'h176, 12'h577,
          12'h376, 12'h0f4, 12'h0f5, 12'h001, 12'h011, 12'h012, 12'h053, 12'h032},
        '{12'h0f4, 12'h012, 12'h032, 12'h033, 12'h034, 12'h0b4, 12'h0b5, 12'h2b6,
          12'h1b5, 12'h073, 12'h074, 12'h023, 12'h000, 12'h001, 12'h022, 12'h011},
        '{12'h1f5, 12'h033, 12'h073, 12'h074, 12'h075, 12'h175, 12'h176, 12'h577,
          12'h376, 12'h0f4, 12'h0f5, 12'h012, 12'h053, 12'h001, 12'h011, 12'h032},
        '{12'h0f4, 12'h012, 12'h032, 12'h033, 12'h034, 12'h0b4, 12'h0b5, 12'h2b6,
          12'h1b5, 12'h073, 12'h074, 12'h001, 12'h022, 12'h023, 12'h000, 12'h011},
        '{12'h073, 12'h001, 12'h011, 12'h012, 12'h013, 12'h053, 12'h054, 12'h155,
          12'h0d4, 12'h032, 12'h033, 12'h034, 12'h0b4, 12'h0b5, 12'h2b6, 12'h000}
    };

    // Microcode
    typedef logic [2:0] t_pc;

    localparam t_pc PC_FETCH = 3'd0;
    localparam t_pc PC_LOAD  = 3'd1;
    localparam t_pc PC_WALK  = 3'd2;
    localparam t_pc PC_SHIFT = 3'd3;
    localparam t_pc PC_RAW   = 3'd4;

    typedef enum logic [2:0] {
        UOP_FETCH,
        UOP_LOAD,
        UOP_WALK,
        UOP_SHIFT,
        UOP_RAW
    } t_op;

    typedef struct packed {
        t_op  op;
        logic dispatch;   // next step chosen by item kind
        t_pc  next_pc;
        t_pc  alt_pc;     // taken when the datapath raises branch
    } t_uop;

    // Datapath status toward the sequencer
    typedef struct packed {
        logic       hold;
        logic       branch;
        logic [1:0] kind;
    } t_seq_cond;

    function automatic t_uop ucode(input t_pc pc);
        t_uop w;
        case (pc)
            PC_FETCH: w = '{op: UOP_FETCH, dispatch: 1'b1, next_pc: PC_FETCH, alt_pc: PC_FETCH};
            PC_LOAD:  w = '{op: UOP_LOAD,  dispatch: 1'b0, next_pc: PC_WALK,  alt_pc: PC_FETCH};
            PC_WALK:  w = '{op: UOP_WALK,  dispatch: 1'b0, next_pc: PC_WALK,  alt_pc: PC_FETCH};
            PC_SHIFT: w = '{op: UOP_SHIFT, dispatch: 1'b0, next_pc: PC_FETCH, alt_pc: PC_LOAD};
            PC_RAW:   w = '{op: UOP_RAW,   dispatch: 1'b0, next_pc: PC_FETCH, alt_pc: PC_FETCH};
            default:  w = '{op: UOP_FETCH, dispatch: 1'b1, next_pc: PC_FETCH, alt_pc: PC_FETCH};
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/jtsq_useq.sv =====
// Microcode sequencer: step counter, control store and jump logic.
`default_nettype none
module jtsq_useq
    import jtsq_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_seq_cond i_cond,
    output t_uop           o_uop
);

    t_pc r_pc;
    t_pc n_pc;

    assign o_uop = ucode(r_pc);

    always_comb begin
        if (i_cond.hold) begin
            n_pc = r_pc;
        end else if (o_uop.dispatch) begin
            case (i_cond.kind)
                KIND_GOTO:  n_pc = PC_LOAD;
                KIND_SHIFT: n_pc = PC_SHIFT;
                KIND_RAW:   n_pc = PC_RAW;
                default:    n_pc = PC_FETCH;   // unused kind is dropped
            endcase
        end else if (i_cond.branch) begin
            n_pc = o_uop.alt_pc;
        end else begin
            n_pc = o_uop.next_pc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_FETCH;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/jtag_tap_master_sequencer.sv =====
// Top level of the JTAG TAP master sequencer: datapath, output register and sequencer.
//
// Each accepted input word is run by a small microcode program, one control word per
// clock when nothing stalls, and gives zero or more TCK-cycle words on the output. The
// fetch step takes the word and dispatches on its kind; a raw word or a shift bit then
// has its own emit step, and a goto has a load step for its path and a walk step per
// TCK cycle emitted (up to 9 words for a reset walk, 8 for a table path). A last shift
// bit adds the load step and the walk to the end state. One output word is made per
// clock at most, set by the single-entry output register; the next input word is taken
// while the last output word still waits. The tap position resets to Test-Logic-Reset.
`default_nettype none
module jtag_tap_master_sequencer
    import jtsq_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [1:0] i_kind,
    input  wire logic [3:0] i_target_state,
    input  wire logic [3:0] i_end_state,
    input  wire logic       i_tdi_bit,
    input  wire logic       i_tms_bit,
    input  wire logic       i_last_bit,
    input  wire logic       i_want_tdo,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic            o_clock_pulse,
    output logic            o_tms_out,
    output logic            o_tdi_out,
    output logic            o_capture_tdo,
    output logic            o_status,
    output logic            o_last
);

    t_uop      uop;
    t_seq_cond cond;

    jtsq_useq u_useq (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cond (cond),
        .o_uop  (uop)
    );

    // Tracked position and walk registers
    logic [3:0] r_pos, n_pos;
    logic [7:0] r_bits, n_bits;
    logic [3:0] r_cnt, n_cnt;
    logic       r_rst_walk, n_rst_walk;
    logic       r_after_shift, n_after_shift;
    logic [3:0] r_target, n_target;

    // Latched input word
    logic [3:0] r_end_state, n_end_state;
    logic       r_tdi, n_tdi;
    logic       r_tms, n_tms;
    logic       r_last_bit, n_last_bit;
    logic       r_want, n_want;

    // Output register
    logic r_out_valid, n_out_valid;
    logic r_clk_o, n_clk_o;
    logic r_tms_o, n_tms_o;
    logic r_tdi_o, n_tdi_o;
    logic r_cap_o, n_cap_o;
    logic r_sts_o, n_sts_o;
    logic r_last_o, n_last_o;

    logic        can_emit;
    logic        emit;
    logic        in_shift;
    logic        leave;
    logic [3:0]  shift_pos;
    logic [11:0] load_entry;
    logic [11:0] end_entry;
    logic        walk_empty;

    assign can_emit   = !r_out_valid || i_out_ready;
    assign in_shift   = (r_pos inside {ST_SHDR, ST_SHIR});
    assign leave      = r_last_bit && !(r_end_state inside {ST_SHDR, ST_SHIR});
    assign shift_pos  = leave ? ((r_pos == ST_SHDR) ? ST_EX1DR : ST_EX1IR) : r_pos;
    assign load_entry = PATH_TAB[r_pos][r_target];
    assign end_entry  = PATH_TAB[shift_pos][r_end_state];
    // walk after the last bit gives nothing: this bit's word closes the item
    assign walk_empty = (r_end_state != ST_TLR) && (end_entry[3:0] == 4'd0);

    assign o_in_ready = (uop.op == UOP_FETCH);

    always_comb begin
        n_pos         = r_pos;
        n_bits        = r_bits;
        n_cnt         = r_cnt;
        n_rst_walk    = r_rst_walk;
        n_after_shift = r_after_shift;
        n_target      = r_target;
        n_end_state   = r_end_state;
        n_tdi         = r_tdi;
        n_tms         = r_tms;
        n_last_bit    = r_last_bit;
        n_want        = r_want;
        emit          = 1'b0;
        n_clk_o       = r_clk_o;
        n_tms_o       = r_tms_o;
        n_tdi_o       = r_tdi_o;
        n_cap_o       = r_cap_o;
        n_sts_o       = r_sts_o;
        n_last_o      = r_last_o;
        cond.hold     = 1'b0;
        cond.branch   = 1'b0;
        cond.kind     = i_kind;

        case (uop.op)
            UOP_FETCH: begin
                cond.hold = !i_in_valid;
                if (i_in_valid) begin
                    n_target      = i_target_state;
                    n_end_state   = i_end_state;
                    n_tdi         = i_tdi_bit;
                    n_tms         = i_tms_bit;
                    n_last_bit    = i_last_bit;
                    n_want        = i_want_tdo;
                    n_after_shift = 1'b0;
                end
            end
            UOP_LOAD: begin
                if (r_target == ST_TLR) begin
                    n_rst_walk = 1'b1;
                    n_bits     = '0;
                    n_cnt      = r_after_shift ? 4'(RST_SHIFT_CLOCKS) : 4'(RST_GOTO_CLOCKS);
                end else begin
                    n_rst_walk  = 1'b0;
                    n_bits      = load_entry[11:4];
                    n_cnt       = load_entry[3:0];
                    cond.branch = (load_entry[3:0] == 4'd0);
                end
            end
            UOP_WALK: begin
                cond.hold = !can_emit;
                if (can_emit) begin
                    emit     = 1'b1;
                    n_clk_o  = 1'b1;
                    n_tms_o  = r_rst_walk | r_bits[0];
                    n_tdi_o  = 1'b0;
                    n_cap_o  = 1'b0;
                    n_sts_o  = 1'b0;
                    n_last_o = (r_cnt == 4'd1);
                    n_bits   = {1'b0, r_bits[7:1]};
                    n_cnt    = r_cnt - 4'd1;
                    if (r_cnt == 4'd1) begin
                        cond.branch = 1'b1;
                        n_pos       = r_target;
                    end
                end
            end
            UOP_SHIFT: begin
                cond.hold = !can_emit;
                if (can_emit) begin
                    emit = 1'b1;
                    if (!in_shift) begin
                        n_clk_o  = 1'b0;
                        n_tms_o  = 1'b0;
                        n_tdi_o  = 1'b0;
                        n_cap_o  = 1'b0;
                        n_sts_o  = 1'b1;
                        n_last_o = 1'b1;
                    end else begin
                        n_clk_o       = 1'b1;
                        n_tms_o       = leave;
                        n_tdi_o       = r_tdi;
                        n_cap_o       = r_want;
                        n_sts_o       = 1'b0;
                        n_last_o      = !r_last_bit || walk_empty;
                        n_pos         = shift_pos;
                        cond.branch   = r_last_bit;
                        n_target      = r_end_state;
                        n_after_shift = 1'b1;
                    end
                end
            end
            UOP_RAW: begin
                cond.hold = !can_emit;
                if (can_emit) begin
                    emit     = 1'b1;
                    n_clk_o  = 1'b1;
                    n_tms_o  = r_tms;
                    n_tdi_o  = r_tdi;
                    n_cap_o  = r_want;
                    n_sts_o  = 1'b0;
                    n_last_o = 1'b1;
                end
            end
            default: begin
                cond.hold = 1'b0;
            end
        endcase

        if (emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos         <= ST_TLR;
            r_bits        <= '0;
            r_cnt         <= '0;
            r_rst_walk    <= 1'b0;
            r_after_shift <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_pos         <= n_pos;
            r_bits        <= n_bits;
            r_cnt         <= n_cnt;
            r_rst_walk    <= n_rst_walk;
            r_after_shift <= n_after_shift;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_target    <= n_target;
        r_end_state <= n_end_state;
        r_tdi       <= n_tdi;
        r_tms       <= n_tms;
        r_last_bit  <= n_last_bit;
        r_want      <= n_want;
        r_clk_o     <= n_clk_o;
        r_tms_o     <= n_tms_o;
        r_tdi_o     <= n_tdi_o;
        r_cap_o     <= n_cap_o;
        r_sts_o     <= n_sts_o;
        r_last_o    <= n_last_o;
    end

    assign o_out_valid   = r_out_valid;
    assign o_clock_pulse = r_clk_o;
    assign o_tms_out     = r_tms_o;
    assign o_tdi_out     = r_tdi_o;
    assign o_capture_tdo = r_cap_o;
    assign o_status      = r_sts_o;
    assign o_last        = r_last_o;

endmodule
`default_nettype wire
